// ===== rtl/core/bvfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bvfs_pkg
// Shared constants and types of the bilinear vector field sampler.
// ----------------------------------------------------------------------------
package bvfs_pkg;

	localparam int MAP_COLS   = 256;
	localparam int MAP_ROWS   = 256;
	localparam int FRAC_BITS  = 16;
	localparam int COL_BITS   = $clog2(MAP_COLS);
	localparam int ROW_BITS   = $clog2(MAP_ROWS);
	// four banks by row and column parity, so a 2x2 cell hits each bank once
	localparam int BANK_AW    = COL_BITS - 1 + ROW_BITS - 1;
	localparam int BANK_DEPTH = (MAP_COLS / 2) * (MAP_ROWS / 2);

	localparam int VAL_W  = 32;
	localparam int D_W    = VAL_W + 1;             // pos - origin
	localparam int P_W    = D_W + VAL_W;           // product with inv_step
	localparam int C_W    = P_W - FRAC_BITS + 1;   // cell coordinate
	localparam int CI_W   = C_W - FRAC_BITS;       // integer cell index
	localparam int A_W    = VAL_W + FRAC_BITS + 3; // row blend
	localparam int Q0_W   = A_W - FRAC_BITS;
	localparam int Q_W    = A_W + 3;               // column blend, integer part
	localparam int R_W    = 2 * FRAC_BITS + 3;     // column blend, remainders
	localparam int HALF   = 1 << (FRAC_BITS - 1);

	localparam int REG_IDX_W = 3;
	localparam int SIZE_W    = 9;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_INV_STEP_X = 3'd2,
		REG_INV_STEP_Y = 3'd3,
		REG_SHIFT_X    = 3'd4,
		REG_SHIFT_Y    = 3'd5,
		REG_COLS_USED  = 3'd6,
		REG_ROWS_USED  = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		MAP_X = 1'b0,
		MAP_Y = 1'b1
	} map_sel_t;

endpackage

// ===== rtl/core/bvfs_intf.sv =====
// ----------------------------------------------------------------------------
// bvfs channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface bvfs_in_if;
	import bvfs_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic              which_map;
	logic [7:0]        load_col;
	logic [7:0]        load_row;
	logic signed [31:0] load_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	modport source (output valid, op, which_map, load_col, load_row, load_value, pos_x, pos_y,
		input ready);
	modport sink (input valid, op, which_map, load_col, load_row, load_value, pos_x, pos_y,
		output ready);
endinterface

interface bvfs_out_if;
	logic               valid;
	logic               ready;
	logic               inside_res;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	modport source (output valid, inside_res, vel_x, vel_y, input ready);
	modport sink (input valid, inside_res, vel_x, vel_y, output ready);
endinterface

interface bvfs_cfg_if;
	import bvfs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bilinear_vector_field_sampler_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_vector_field_sampler_top
// Bilinear sampler of a two-component grid velocity field.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries load items (op = 0) that write one sample of the x or y map,
//   and query items (op = 1) with a Q16.16 position. Each query gives one
//   item on out_ch; loads give none. cfg writes the registers and is always
//   ready; write it only while the block is idle.
//   A query result passes stages 1 to 7 in order. Throughput: one item per
//   cycle while out_ch is ready, set by the seven-stage pipeline with one
//   2x2 read per cycle from four parity banks per map.
//   A load writes its bank in the same stage where queries read, so loads
//   and queries are seen in accepted order. Reading a never-written sample
//   gives undefined data.
//   Reset clears all stage valid bits and loads register defaults; the map
//   contents are kept. A stalled receiver holds the output item; stages
//   behind it keep filling bubbles and then stop without losing anything.
// ----------------------------------------------------------------------------
module bilinear_vector_field_sampler_top (
	input  logic         clk,
	input  logic         arst_n,
	bvfs_in_if.sink      in_ch,
	bvfs_out_if.source   out_ch,
	bvfs_cfg_if.sink     cfg
);
	import bvfs_pkg::*;

	logic signed [31:0] origin_x_q, origin_y_q, inv_step_x_q, inv_step_y_q;
	logic signed [31:0] shift_x_q, shift_y_q;
	logic [SIZE_W-1:0]  cols_used_q, rows_used_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			inv_step_x_q <= 32'sd65536;
			inv_step_y_q <= 32'sd65536;
			shift_x_q    <= '0;
			shift_y_q    <= '0;
			cols_used_q  <= SIZE_W'(256);
			rows_used_q  <= SIZE_W'(256);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ORIGIN_X:   origin_x_q   <= cfg.data;
				REG_ORIGIN_Y:   origin_y_q   <= cfg.data;
				REG_INV_STEP_X: inv_step_x_q <= cfg.data;
				REG_INV_STEP_Y: inv_step_y_q <= cfg.data;
				REG_SHIFT_X:    shift_x_q    <= cfg.data;
				REG_SHIFT_Y:    shift_y_q    <= cfg.data;
				REG_COLS_USED:  cols_used_q  <= cfg.data[SIZE_W-1:0];
				REG_ROWS_USED:  rows_used_q  <= cfg.data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || out_ch.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;

	// load fields travel to the memory stage
	logic               query_s1, query_s2, query_s3;
	logic               map_s1, map_s2, map_s3;
	logic [7:0]         col_s1, col_s2, col_s3;
	logic [7:0]         row_s1, row_s2, row_s3;
	logic signed [31:0] val_s1, val_s2, val_s3;

	// stage 1: offset from origin
	logic signed [D_W-1:0] dx_s1, dy_s1;
	// stage 2: scaled
	logic signed [P_W-1:0] px_s2, py_s2;
	// stage 3: cell index and weights
	logic [FRAC_BITS-1:0] fx_s3, fy_s3;
	logic [COL_BITS-1:0]  ix_s3;
	logic [ROW_BITS-1:0]  iy_s3;
	logic                 inside_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			query_s1 <= (in_ch.op == OP_QUERY);
			map_s1   <= in_ch.which_map;
			col_s1   <= in_ch.load_col;
			row_s1   <= in_ch.load_row;
			val_s1   <= in_ch.load_value;
			dx_s1    <= D_W'(in_ch.pos_x) - D_W'(origin_x_q);
			dy_s1    <= D_W'(in_ch.pos_y) - D_W'(origin_y_q);
		end
		if (en2) begin
			query_s2 <= query_s1;
			map_s2   <= map_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			val_s2   <= val_s1;
			px_s2    <= dx_s1 * inv_step_x_q;
			py_s2    <= dy_s1 * inv_step_y_q;
		end
	end

	logic signed [C_W-1:0]  cx, cy;
	logic signed [CI_W-1:0] cix, ciy, xlim, ylim;
	logic [SIZE_W-1:0]      ncols, nrows;

	always_comb begin
		cx    = C_W'(px_s2 >>> FRAC_BITS) + C_W'(HALF) + C_W'(shift_x_q);
		cy    = C_W'(py_s2 >>> FRAC_BITS) + C_W'(HALF) + C_W'(shift_y_q);
		cix   = cx[C_W-1:FRAC_BITS];
		ciy   = cy[C_W-1:FRAC_BITS];
		ncols = (cols_used_q > SIZE_W'(MAP_COLS)) ? SIZE_W'(MAP_COLS) : cols_used_q;
		nrows = (rows_used_q > SIZE_W'(MAP_ROWS)) ? SIZE_W'(MAP_ROWS) : rows_used_q;
		xlim  = CI_W'(ncols) - CI_W'(2);
		ylim  = CI_W'(nrows) - CI_W'(2);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			query_s3  <= query_s2;
			map_s3    <= map_s2;
			col_s3    <= col_s2;
			row_s3    <= row_s2;
			val_s3    <= val_s2;
			fx_s3     <= cx[FRAC_BITS-1:0];
			fy_s3     <= cy[FRAC_BITS-1:0];
			ix_s3     <= cix[COL_BITS-1:0];
			iy_s3     <= ciy[ROW_BITS-1:0];
			inside_s3 <= (cix >= signed'(CI_W'(1))) && (cix <= xlim)
				&& (ciy >= signed'(CI_W'(1))) && (ciy <= ylim);
		end
	end

	// stage 4: banked map access; loads write here and retire
	logic [31:0] rdx_s4 [4];
	logic [31:0] rdy_s4 [4];
	logic        ld_go;

	assign ld_go = en4 && v_s3 && !query_s3;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] BID = 2'(b);
		logic [31:0]         mem_x [BANK_DEPTH];
		logic [31:0]         mem_y [BANK_DEPTH];
		logic [COL_BITS-1:0] qcol;
		logic [ROW_BITS-1:0] qrow;
		logic [BANK_AW-1:0]  addr;
		logic                hit;

		always_comb begin
			qcol = (ix_s3[0] == BID[0]) ? ix_s3 : ix_s3 + COL_BITS'(1);
			qrow = (iy_s3[0] == BID[1]) ? iy_s3 : iy_s3 + ROW_BITS'(1);
			hit  = ld_go && (col_s3[0] == BID[0]) && (row_s3[0] == BID[1]);
			if (query_s3)
				addr = {qrow[ROW_BITS-1:1], qcol[COL_BITS-1:1]};
			else
				addr = {row_s3[ROW_BITS-1:1], col_s3[COL_BITS-1:1]};
		end

		always_ff @(posedge clk) begin
			if (en4) begin
				if (hit && map_s3 == MAP_X) mem_x[addr] <= val_s3;
				if (hit && map_s3 == MAP_Y) mem_y[addr] <= val_s3;
				rdx_s4[b] <= mem_x[addr];
				rdy_s4[b] <= mem_y[addr];
			end
		end
	end

	logic [FRAC_BITS-1:0] fx_s4, fy_s4, fy_s5;
	logic                 ix0_s4, iy0_s4, inside_s4, inside_s5, inside_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en4) v_s4 <= v_s3 && query_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			fx_s4     <= fx_s3;
			fy_s4     <= fy_s3;
			ix0_s4    <= ix_s3[0];
			iy0_s4    <= iy_s3[0];
			inside_s4 <= inside_s3;
		end
	end

	// stage 5: blend along x, one multiply per row
	logic signed [A_W-1:0] ax0_s5, ax1_s5, ay0_s5, ay1_s5;
	logic signed [A_W-1:0] ax0, ax1, ay0, ay1;
	logic signed [FRAC_BITS:0] fxs;
	logic [1:0] b00, b01, b10, b11;

	function automatic logic signed [A_W-1:0] row_mix(input logic [31:0] m0,
		input logic [31:0] m1, input logic signed [FRAC_BITS:0] f);
		logic signed [D_W-1:0] d;
		logic signed [D_W+FRAC_BITS:0] p;
		d = D_W'(signed'(m1)) - D_W'(signed'(m0));
		p = f * d;
		return (A_W'(signed'(m0)) <<< FRAC_BITS) + A_W'(p);
	endfunction

	always_comb begin
		fxs = signed'({1'b0, fx_s4});
		b00 = {iy0_s4, ix0_s4};
		b01 = {iy0_s4, !ix0_s4};
		b10 = {!iy0_s4, ix0_s4};
		b11 = {!iy0_s4, !ix0_s4};
		ax0 = row_mix(rdx_s4[b00], rdx_s4[b01], fxs);
		ax1 = row_mix(rdx_s4[b10], rdx_s4[b11], fxs);
		ay0 = row_mix(rdy_s4[b00], rdy_s4[b01], fxs);
		ay1 = row_mix(rdy_s4[b10], rdy_s4[b11], fxs);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			ax0_s5    <= ax0;
			ax1_s5    <= ax1;
			ay0_s5    <= ay0;
			ay1_s5    <= ay1;
			fy_s5     <= fy_s4;
			inside_s5 <= inside_s4;
		end
	end

	// stage 6: blend along y, integer parts and remainders kept apart
	logic signed [Q_W-1:0] qx_s6, qy_s6, qx, qy;
	logic signed [R_W-1:0] rx_s6, ry_s6, rx, ry;
	logic signed [FRAC_BITS:0] fys;

	function automatic logic signed [Q_W-1:0] col_q(input logic signed [A_W-1:0] a0,
		input logic signed [A_W-1:0] a1, input logic signed [FRAC_BITS:0] f);
		logic signed [Q0_W-1:0] q0, q1;
		logic signed [Q0_W:0] d;
		logic signed [Q0_W+FRAC_BITS+1:0] p;
		q0 = Q0_W'(a0 >>> FRAC_BITS);
		q1 = Q0_W'(a1 >>> FRAC_BITS);
		d  = (Q0_W+1)'(q1) - (Q0_W+1)'(q0);
		p  = f * d;
		return (Q_W'(q0) <<< FRAC_BITS) + Q_W'(p);
	endfunction

	function automatic logic signed [R_W-1:0] col_r(input logic signed [A_W-1:0] a0,
		input logic signed [A_W-1:0] a1, input logic signed [FRAC_BITS:0] f);
		logic signed [FRAC_BITS:0] r0, r1, d;
		logic signed [2*FRAC_BITS+1:0] p;
		r0 = signed'({1'b0, a0[FRAC_BITS-1:0]});
		r1 = signed'({1'b0, a1[FRAC_BITS-1:0]});
		d  = r1 - r0;
		p  = f * d;
		return (R_W'(r0) <<< FRAC_BITS) + R_W'(p);
	endfunction

	always_comb begin
		fys = signed'({1'b0, fy_s5});
		qx  = col_q(ax0_s5, ax1_s5, fys);
		qy  = col_q(ay0_s5, ay1_s5, fys);
		rx  = col_r(ax0_s5, ax1_s5, fys);
		ry  = col_r(ay0_s5, ay1_s5, fys);
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			qx_s6     <= qx;
			qy_s6     <= qy;
			rx_s6     <= rx;
			ry_s6     <= ry;
			inside_s6 <= inside_s5;
		end
	end

	// stage 7: final floor, border answers zero
	logic signed [Q_W-1:0] tx, ty;
	logic                  inside_s7;
	logic signed [31:0]    vel_x_s7, vel_y_s7;

	always_comb begin
		tx = (qx_s6 + Q_W'(rx_s6 >>> FRAC_BITS)) >>> FRAC_BITS;
		ty = (qy_s6 + Q_W'(ry_s6 >>> FRAC_BITS)) >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			inside_s7 <= inside_s6;
			vel_x_s7  <= inside_s6 ? tx[31:0] : '0;
			vel_y_s7  <= inside_s6 ? ty[31:0] : '0;
		end
	end

	assign out_ch.valid      = v_s7;
	assign out_ch.inside_res = inside_s7;
	assign out_ch.vel_x      = vel_x_s7;
	assign out_ch.vel_y      = vel_y_s7;

endmodule

// ===== rtl/core/bvfs_checker.sv =====
// ----------------------------------------------------------------------------
// bvfs_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bvfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        inside_res,
	input logic [31:0] vel_x,
	input logic [31:0] vel_y
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inside_res)
			&& $stable(vel_x) && $stable(vel_y))
		else $error("result item changed while stalled");

	// border answers carry zero velocity
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> vel_x == 32'd0 && vel_y == 32'd0)
		else $error("border result with nonzero velocity");

	// with the output free nothing can block the input
	a_free_ready: assert property (@(posedge clk)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result item during reset");

endmodule

bind bilinear_vector_field_sampler_top bvfs_checker u_bvfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.inside_res (out_ch.inside_res),
	.vel_x      (out_ch.vel_x),
	.vel_y      (out_ch.vel_y)
);
